// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define UDL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when true, forces another one in the following cycle.
`define UDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/utf8dl_pkg.sv =====
// Types, codes and classification functions of the UTF-8 decoder.
package utf8dl_pkg;

  localparam int CpW    = 21;
  localparam int LenW   = 3;
  localparam int ByteW  = 8;
  localparam int UpperW = 9;

  localparam logic [1:0] TAIL_NONE  = 2'd0;
  localparam logic [1:0] TAIL_VALID = 2'd1;
  localparam logic [1:0] TAIL_ERROR = 2'd2;

  // One decoded byte: up to three flushed bytes reported as errors, then an optional tail.
  typedef struct packed {
    logic [1:0]              nerr;
    logic [2:0][ByteW-1:0]   flush;
    logic [1:0]              tail_kind;
    logic [CpW-1:0]          tail_cp;
    logic [LenW-1:0]         tail_len;
    logic [ByteW-1:0]        tail_byte;
  } job_t;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [LenW-1:0]   seq_length;
    logic              malformed;
    logic [ByteW-1:0]  opaque_byte;
    logic              letter_or_digit;
    logic              has_upper;
    logic [UpperW-1:0] upper_code_point;
    logic              last_of_run;
  } result_t;

  function automatic logic is_alnum_latin(input logic [CpW-1:0] v);
    logic res;
    if (v < 21'h80) begin
      res = (v >= 21'h30 && v <= 21'h39) || (v >= 21'h41 && v <= 21'h5A) ||
            (v >= 21'h61 && v <= 21'h7A);
    end else begin
      res = v >= 21'h0C0 && v <= 21'h24F && v != 21'h0D7 && v != 21'h0F7;
    end
    return res;
  endfunction

  function automatic logic [UpperW-1:0] upper_of(input logic [CpW-1:0] v);
    logic [UpperW-1:0] lo;
    logic              odd_run;
    logic              even_run;
    logic [UpperW-1:0] res;
    lo       = v[UpperW-1:0];
    odd_run  = (v >= 21'h100 && v <= 21'h12F) || (v >= 21'h132 && v <= 21'h137) ||
               (v >= 21'h14A && v <= 21'h177);
    even_run = (v >= 21'h139 && v <= 21'h148) || (v >= 21'h179 && v <= 21'h17E);
    if (v >= 21'h61 && v <= 21'h7A) begin
      res = lo - 9'h020;
    end else if (v >= 21'h0E0 && v <= 21'h0FE && v != 21'h0F7) begin
      res = lo - 9'h020;
    end else if (v == 21'h0FF) begin
      res = 9'h178;
    end else if (v == 21'h131) begin
      res = 9'h049;
    end else if (odd_run && v[0]) begin
      res = lo - 9'h001;
    end else if (even_run && !v[0]) begin
      res = lo - 9'h001;
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

// ===== hdl/utf8dl_front.sv =====
// Front end: sequence tracking of the byte stream and job building per accepted byte.
module utf8dl_front
  import utf8dl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [ByteW-1:0] data_byte,
  input  logic             end_of_text,
  output logic             job_valid,
  output job_t             job
);

  logic [CpW-1:0]   pv_r, pv_nxt;
  logic [2:0]       exp_r, exp_nxt;
  logic [1:0]       held_r, held_nxt;
  logic [ByteW-1:0] hb_r [0:2];
  logic [ByteW-1:0] hb_nxt [0:2];

  logic           cont;
  logic [CpW-1:0] pv_ext;
  logic [2:0]     lead_len;
  logic [CpW-1:0] lead_bits;

  assign cont   = data_byte[7:6] == 2'b10;
  assign pv_ext = {pv_r[CpW-7:0], data_byte[5:0]};

  always_comb begin
    lead_len  = 3'd0;
    lead_bits = '0;
    priority if (data_byte[7] == 1'b0) begin
      lead_len  = 3'd1;
      lead_bits = {13'd0, data_byte};
    end else if (data_byte[7:5] == 3'b110) begin
      lead_len  = 3'd2;
      lead_bits = {16'd0, data_byte[4:0]};
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_len  = 3'd3;
      lead_bits = {17'd0, data_byte[3:0]};
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_len  = 3'd4;
      lead_bits = {18'd0, data_byte[2:0]};
    end else begin
      lead_len  = 3'd0;
    end
  end

  always_comb begin
    pv_nxt   = pv_r;
    exp_nxt  = exp_r;
    held_nxt = held_r;
    for (int i = 0; i < 3; i++) begin
      hb_nxt[i]    = hb_r[i];
      job.flush[i] = hb_r[i];
    end
    job.nerr      = 2'd0;
    job.tail_kind = TAIL_NONE;
    job.tail_cp   = '0;
    job.tail_len  = 3'd1;
    job.tail_byte = data_byte;
    if (exp_r != 3'd0 && cont) begin
      if ({1'b0, held_r} + 3'd1 == exp_r) begin
        job.tail_kind = TAIL_VALID;
        job.tail_cp   = pv_ext;
        job.tail_len  = exp_r;
        job.tail_byte = hb_r[0];
        pv_nxt        = '0;
        exp_nxt       = 3'd0;
        held_nxt      = 2'd0;
      end else if (end_of_text || held_r == 2'd3) begin
        job.nerr      = held_r;
        job.tail_kind = TAIL_ERROR;
        pv_nxt        = '0;
        exp_nxt       = 3'd0;
        held_nxt      = 2'd0;
      end else begin
        hb_nxt[held_r] = data_byte;
        held_nxt       = held_r + 2'd1;
        pv_nxt         = pv_ext;
      end
    end else begin
      job.nerr = (exp_r != 3'd0) ? held_r : 2'd0;
      pv_nxt   = '0;
      exp_nxt  = 3'd0;
      held_nxt = 2'd0;
      if (lead_len == 3'd1) begin
        job.tail_kind = TAIL_VALID;
        job.tail_cp   = lead_bits;
      end else if (lead_len != 3'd0 && !end_of_text) begin
        pv_nxt    = lead_bits;
        exp_nxt   = lead_len;
        held_nxt  = 2'd1;
        hb_nxt[0] = data_byte;
      end else begin
        job.tail_kind = TAIL_ERROR;
      end
    end
  end

  assign job_valid = accept && (job.nerr != 2'd0 || job.tail_kind != TAIL_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r   <= '0;
      exp_r  <= 3'd0;
      held_r <= 2'd0;
    end else if (accept) begin
      pv_r   <= pv_nxt;
      exp_r  <= exp_nxt;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        hb_r[i] <= hb_nxt[i];
      end
    end
  end

`include "assert_macros.svh"

  `UDL_ASSERT(a_idle_holds_nothing, exp_r != 3'd0 || held_r == 2'd0, "bytes held with no sequence")
  `UDL_ASSERT(a_pending_shape, exp_r == 3'd0 || (held_r != 2'd0 && {1'b0, held_r} < exp_r), "held count out of range")

endmodule

// ===== hdl/utf8dl_queue.sv =====
// Short job queue between the front and back ends.
module utf8dl_queue
  import utf8dl_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  job_t            mem_r [0:DEPTH-1];
  logic [PtrW-1:0] wr_r, wr_nxt;
  logic [PtrW-1:0] rd_r, rd_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == FullCnt;
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == LastPtr) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == LastPtr) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

`include "assert_macros.svh"

  `UDL_ASSERT(a_no_overrun, !(push && full) && !(pop && empty), "queue overrun or underrun")

endmodule

// ===== hdl/utf8dl_back.sv =====
// Back end: expands each job into results, classifies them and holds the output register.
module utf8dl_back
  import utf8dl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    empty,
  input  job_t    head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  result_t    res_r, res_nxt;
  logic       load;
  logic       is_tail;
  logic       last;

  assign load    = !empty && (!vld_r || out_ready);
  assign is_tail = idx_r >= head.nerr;
  assign last    = is_tail || (idx_r == head.nerr - 2'd1 && head.tail_kind == TAIL_NONE);
  assign pop     = load && last;

  always_comb begin
    res_nxt                  = '0;
    res_nxt.seq_length       = 3'd1;
    res_nxt.last_of_run      = last;
    if (is_tail && head.tail_kind == TAIL_VALID) begin
      res_nxt.code_point       = head.tail_cp;
      res_nxt.seq_length       = head.tail_len;
      res_nxt.opaque_byte      = head.tail_byte;
      res_nxt.letter_or_digit  = is_alnum_latin(head.tail_cp);
      res_nxt.upper_code_point = upper_of(head.tail_cp);
      res_nxt.has_upper        = res_nxt.upper_code_point != '0;
    end else begin
      res_nxt.malformed   = 1'b1;
      res_nxt.opaque_byte = is_tail ? head.tail_byte : head.flush[idx_r];
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    if (load) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

`include "assert_macros.svh"

  `UDL_ASSERT_NEXT(a_pop_restarts, pop, idx_r == 2'd0 && vld_r, "job index not restarted after pop")

endmodule

// ===== hdl/utf8_decode_latin_classify.sv =====
// Top level of the UTF-8 decoder with Latin letter classification and uppercase map.
//
//   Channel   Direction  Payload
//   in_*      slave      tdata: data_byte; tlast: end_of_text
//   out_*     master     tdata: code_point .. upper_code_point; tuser: malformed;
//                        tlast: last_of_run
//
// One byte is accepted per cycle while the job queue has room; results pass through the queue and the output register.
// A byte that causes N results holds the back end until all N are out, one result per cycle while out_tready is high.
// The back-end output register sets the result rate, and the queue absorbs short bursts.
// Reset is synchronous and active low; it clears the sequence state, the queue and the output.
// Either side may stall at any time without losing or repeating a transfer.
module utf8_decode_latin_classify
  import utf8dl_pkg::*;
#(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [20:0] code_point, [23:21] seq_length,
                                  // [31:24] opaque_byte, [32] letter_or_digit,
                                  // [33] has_upper, [42:34] upper_code_point, rest zero
  output logic [0:0]  out_tuser,  // [0] malformed
  output logic        out_tlast
);

  logic    accept;
  logic    job_valid;
  job_t    job;
  logic    full;
  logic    empty;
  logic    pop;
  job_t    head;
  result_t res;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  utf8dl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_tdata),
    .end_of_text (in_tlast),
    .job_valid   (job_valid),
    .job         (job)
  );

  utf8dl_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_valid),
    .push_job (job),
    .full     (full),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  utf8dl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'd0, res.upper_code_point, res.has_upper, res.letter_or_digit,
                      res.opaque_byte, res.seq_length, res.code_point};
  assign out_tuser = res.malformed;
  assign out_tlast = res.last_of_run;

endmodule
